[src/atl_pkg.sv]
`timescale 1ns / 1ps
package atl_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAG_FRAC     = 8;
    localparam int SUM_W        = 2 * SAMPLE_WIDTH;
    localparam int RAD_W        = SUM_W + 2 * MAG_FRAC;
    localparam int MAG_W        = RAD_W / 2;
    localparam int CW           = MAG_W + 3;
    localparam int ZW           = 32;
    localparam int CORDIC_STEPS = 30;
    localparam int LANES        = 3;
    localparam int DEG_W        = 8;

    // degrees = floor(z * DEG_NUM / (DEG_DEN * 2^RAD_FRAC))
    localparam int DEG_NUM      = 57295;
    localparam int DEG_NUM_W    = 16;
    localparam int RAD_FRAC     = 30;
    localparam int DEG_DEN      = 1000;
    localparam int DEG_DEN_W    = 10;
    localparam int RECIP        = 1049;
    localparam int RECIP_W      = 11;
    localparam int RECIP_SHIFT  = 20;
    localparam int PROD_W       = (ZW - 1) + DEG_NUM_W;
    localparam int T_W          = PROD_W - RAD_FRAC;
    localparam int RP_W         = T_W + RECIP_W;
    localparam int Q_W          = RP_W - RECIP_SHIFT;
    localparam int QP_W         = Q_W + DEG_DEN_W;

    localparam logic signed [DEG_W-1:0] DEG_RIGHT = 8'sd90;
    localparam logic signed [DEG_W-1:0] DEG_NONE  = 8'sd0;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] accel_x;
        logic signed [SAMPLE_WIDTH-1:0] accel_y;
        logic signed [SAMPLE_WIDTH-1:0] accel_z;
    } in_t;

    typedef struct packed {
        logic signed [DEG_W-1:0] angle_about_x;
        logic signed [DEG_W-1:0] angle_about_y;
        logic signed [DEG_W-1:0] angle_about_z;
    } out_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
    } sq_side_t;

    typedef struct packed {
        logic                    neg;
        logic                    spec;
        logic signed [DEG_W-1:0] spec_deg;
    } flag_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 32'sh3243F6A8;
            1:  v = 32'sh1DAC6705;
            2:  v = 32'sh0FADBAFC;
            3:  v = 32'sh07F56EA6;
            4:  v = 32'sh03FEAB76;
            5:  v = 32'sh01FFD55B;
            6:  v = 32'sh00FFFAAA;
            7:  v = 32'sh007FFF55;
            8:  v = 32'sh003FFFEA;
            9:  v = 32'sh001FFFFD;
            10: v = 32'sh000FFFFF;
            11: v = 32'sh0007FFFF;
            12: v = 32'sh0003FFFF;
            13: v = 32'sh0001FFFF;
            14: v = 32'sh0000FFFF;
            15: v = 32'sh00007FFF;
            16: v = 32'sh00003FFF;
            17: v = 32'sh00001FFF;
            18: v = 32'sh00000FFF;
            19: v = 32'sh000007FF;
            20: v = 32'sh000003FF;
            21: v = 32'sh000001FF;
            22: v = 32'sh000000FF;
            23: v = 32'sh0000007F;
            24: v = 32'sh0000003F;
            25: v = 32'sh0000001F;
            26: v = 32'sh0000000F;
            27: v = 32'sh00000008;
            28: v = 32'sh00000004;
            29: v = 32'sh00000002;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/atl_isqrt.sv]
`timescale 1ns / 1ps
// Two-lane digit-by-digit square root, one result bit per stage.
module atl_isqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             vld_in,
    input  logic [atl_pkg::SUM_W-1:0]        sum_xz,
    input  logic [atl_pkg::SUM_W-1:0]        sum_yz,
    input  atl_pkg::sq_side_t                side_in,
    output logic                             vld_out,
    output logic [atl_pkg::MAG_W-1:0]        mag_xz,
    output logic [atl_pkg::MAG_W-1:0]        mag_yz,
    output atl_pkg::sq_side_t                side_out
);
    localparam int N     = atl_pkg::MAG_W;
    localparam int RW    = atl_pkg::RAD_W;
    localparam int REM_W = N + 3;

    logic [RW-1:0]    rad_reg  [N-1][2];
    logic [REM_W-1:0] rem_reg  [N-1][2];
    logic [N-1:0]     root_reg [N][2];
    atl_pkg::sq_side_t side_reg [N];
    logic [N-1:0]     vld_reg;

    for (genvar s = 0; s < N; s++) begin : g_step
        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [RW-1:0]    rad_in;
            logic [REM_W-1:0] rem_in;
            logic [N-1:0]     root_in;
            logic [REM_W-1:0] cur;
            logic [REM_W-1:0] test;

            if (s == 0) begin : g_first
                assign rad_in  = (l == 0) ? {sum_xz, {(2 * atl_pkg::MAG_FRAC){1'b0}}}
                                          : {sum_yz, {(2 * atl_pkg::MAG_FRAC){1'b0}}};
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[s-1][l];
                assign rem_in  = rem_reg[s-1][l];
                assign root_in = root_reg[s-1][l];
            end

            assign cur  = {rem_in[REM_W-3:0], rad_in[RW-1 -: 2]};
            assign test = {1'b0, root_in, 2'b01};

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (cur >= test) begin
                        root_reg[s][l] <= {root_in[N-2:0], 1'b1};
                    end else begin
                        root_reg[s][l] <= {root_in[N-2:0], 1'b0};
                    end
                end
            end

            if (s < N - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        rad_reg[s][l] <= rad_in << 2;
                        rem_reg[s][l] <= (cur >= test) ? cur - test : cur;
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= (s == 0) ? vld_in : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    assign mag_xz   = root_reg[N-1][0];
    assign mag_yz   = root_reg[N-1][1];
    assign side_out = side_reg[N-1];
    assign vld_out  = vld_reg[N-1];

endmodule

[src/atl_cordic.sv]
`timescale 1ns / 1ps
// Three-lane vectoring CORDIC, one rotation per stage.
module atl_cordic (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          vld_in,
    input  logic [atl_pkg::MAG_W-1:0]     a_in   [atl_pkg::LANES],
    input  logic [atl_pkg::MAG_W-1:0]     b_in   [atl_pkg::LANES],
    input  atl_pkg::flag_t                flg_in [atl_pkg::LANES],
    output logic                          vld_out,
    output logic signed [atl_pkg::ZW-1:0] z_out  [atl_pkg::LANES],
    output atl_pkg::flag_t                flg_out [atl_pkg::LANES]
);
    localparam int S  = atl_pkg::CORDIC_STEPS;
    localparam int L  = atl_pkg::LANES;
    localparam int CW = atl_pkg::CW;
    localparam int ZW = atl_pkg::ZW;

    logic signed [CW-1:0] x_reg   [S-1][L];
    logic signed [CW-1:0] y_reg   [S-1][L];
    logic signed [ZW-1:0] z_reg   [S][L];
    atl_pkg::flag_t       flg_reg [S][L];
    logic [S-1:0]         vld_reg;

    for (genvar s = 0; s < S; s++) begin : g_step
        for (genvar l = 0; l < L; l++) begin : g_lane
            logic signed [CW-1:0] x_in;
            logic signed [CW-1:0] y_in;
            logic signed [ZW-1:0] z_in;
            atl_pkg::flag_t       f_in;
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;

            if (s == 0) begin : g_first
                assign x_in = $signed({{(CW - atl_pkg::MAG_W){1'b0}}, b_in[l]});
                assign y_in = $signed({{(CW - atl_pkg::MAG_W){1'b0}}, a_in[l]});
                assign z_in = '0;
                assign f_in = flg_in[l];
            end else begin : g_next
                assign x_in = x_reg[s-1][l];
                assign y_in = y_reg[s-1][l];
                assign z_in = z_reg[s-1][l];
                assign f_in = flg_reg[s-1][l];
            end

            assign xs = x_in >>> s;
            assign ys = y_in >>> s;

            // rotate toward the x axis
            always_ff @(posedge aclk) begin
                if (en) begin
                    flg_reg[s][l] <= f_in;
                    if (!y_in[CW-1]) begin
                        z_reg[s][l] <= z_in + atl_pkg::atan_tab(s);
                    end else begin
                        z_reg[s][l] <= z_in - atl_pkg::atan_tab(s);
                    end
                end
            end

            if (s < S - 1) begin : g_carry
                always_ff @(posedge aclk) begin
                    if (en) begin
                        if (!y_in[CW-1]) begin
                            x_reg[s][l] <= x_in + ys;
                            y_reg[s][l] <= y_in - xs;
                        end else begin
                            x_reg[s][l] <= x_in - ys;
                            y_reg[s][l] <= y_in + xs;
                        end
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[s] <= 1'b0;
            end else if (en) begin
                vld_reg[s] <= (s == 0) ? vld_in : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end
    end

    for (genvar l = 0; l < L; l++) begin : g_out
        assign z_out[l]   = z_reg[S-1][l];
        assign flg_out[l] = flg_reg[S-1][l];
    end
    assign vld_out = vld_reg[S-1];

endmodule

[src/atl_deg.sv]
`timescale 1ns / 1ps
// Radians to truncated degrees: scale, reciprocal divide, correct, sign.
module atl_deg (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             vld_in,
    input  logic signed [atl_pkg::ZW-1:0]    z_in   [atl_pkg::LANES],
    input  atl_pkg::flag_t                   flg_in [atl_pkg::LANES],
    output logic                             vld_out,
    output logic signed [atl_pkg::DEG_W-1:0] deg_out [atl_pkg::LANES]
);
    localparam int L     = atl_pkg::LANES;
    localparam int ZW    = atl_pkg::ZW;
    localparam int PW    = atl_pkg::PROD_W;
    localparam int TW    = atl_pkg::T_W;
    localparam int RPW   = atl_pkg::RP_W;
    localparam int QW    = atl_pkg::Q_W;
    localparam int QPW   = atl_pkg::QP_W;
    localparam int DW    = atl_pkg::DEG_W;

    logic                d1_vld_reg;
    logic                d2_vld_reg;
    logic                d3_vld_reg;
    logic [PW-1:0]       d1_prod_reg [L];
    atl_pkg::flag_t      d1_flg_reg  [L];
    logic [TW-1:0]       d2_t_reg    [L];
    logic [QW-1:0]       d2_q_reg    [L];
    atl_pkg::flag_t      d2_flg_reg  [L];
    logic signed [DW-1:0] d3_deg_reg [L];

    for (genvar l = 0; l < L; l++) begin : g_lane
        logic [ZW-2:0]        zc;
        logic [TW-1:0]        t;
        logic [RPW-1:0]       rp;
        logic [QPW-1:0]       qp;
        logic [QW-1:0]        q;
        logic signed [DW-1:0] mag;
        logic signed [DW-1:0] deg_next;

        // clamp a negative angle to zero
        assign zc = z_in[l][ZW-1] ? '0 : z_in[l][ZW-2:0];
        assign t  = d1_prod_reg[l][PW-1 -: TW];
        assign rp = RPW'(t) * RPW'(atl_pkg::RECIP);
        // estimate is exact or one too high
        assign qp = QPW'(d2_q_reg[l]) * QPW'(atl_pkg::DEG_DEN);
        assign q  = (qp > QPW'(d2_t_reg[l])) ? d2_q_reg[l] - 1'b1 : d2_q_reg[l];
        assign mag = DW'(q);

        always_comb begin
            if (d2_flg_reg[l].spec) begin
                deg_next = d2_flg_reg[l].spec_deg;
            end else if (d2_flg_reg[l].neg) begin
                deg_next = -mag;
            end else begin
                deg_next = mag;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d1_prod_reg[l] <= PW'(zc) * PW'(atl_pkg::DEG_NUM);
                d1_flg_reg[l]  <= flg_in[l];
                d2_t_reg[l]    <= t;
                d2_q_reg[l]    <= rp[RPW-1 -: QW];
                d2_flg_reg[l]  <= d1_flg_reg[l];
                d3_deg_reg[l]  <= deg_next;
            end
        end

        assign deg_out[l] = d3_deg_reg[l];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d1_vld_reg <= 1'b0;
            d2_vld_reg <= 1'b0;
            d3_vld_reg <= 1'b0;
        end else if (en) begin
            d1_vld_reg <= vld_in;
            d2_vld_reg <= d1_vld_reg;
            d3_vld_reg <= d2_vld_reg;
        end
    end

    assign vld_out = d3_vld_reg;

endmodule

[src/accel_tilt_angles_unit.sv]
`timescale 1ns / 1ps
// Pipeline: square and sum stages, square root stages, operand prep, CORDIC
//   rotations, then degree conversion, from input transfer to result valid.
// Throughput: one sample per cycle; the whole pipeline advances together and
//   holds while the result register waits for m_ready.
// Reset: synchronous, active low aresetn clears every stage valid bit; data
//   registers are not reset.
module accel_tilt_angles_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  atl_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output atl_pkg::out_t  m_data
);
    localparam int SW  = atl_pkg::SAMPLE_WIDTH;
    localparam int SUM = atl_pkg::SUM_W;
    localparam int MW  = atl_pkg::MAG_W;
    localparam int FR  = atl_pkg::MAG_FRAC;
    localparam int L   = atl_pkg::LANES;

    // Advance the pipeline unless a finished result is stuck at the output.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------------------------------------------------------
    // Stage A: squares of each axis
    // ---------------------------------------------------------------
    logic signed [SUM-1:0] xe, ye, ze;
    assign xe = SUM'(s_data.accel_x);
    assign ye = SUM'(s_data.accel_y);
    assign ze = SUM'(s_data.accel_z);

    logic                 a_vld_reg;
    logic [SUM-1:0]       a_xsq_reg, a_ysq_reg, a_zsq_reg;
    logic signed [SW-1:0] a_x_reg, a_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_xsq_reg <= xe * xe;
            a_ysq_reg <= ye * ye;
            a_zsq_reg <= ze * ze;
            a_x_reg   <= s_data.accel_x;
            a_y_reg   <= s_data.accel_y;
        end
    end

    // ---------------------------------------------------------------
    // Stage B: sums of squares (at most 2^31, fits without carry out)
    // ---------------------------------------------------------------
    logic              b_vld_reg;
    logic [SUM-1:0]    b_sxz_reg, b_syz_reg;
    atl_pkg::sq_side_t b_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= 1'b0;
        end else if (en) begin
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sxz_reg    <= a_xsq_reg + a_zsq_reg;
            b_syz_reg    <= a_ysq_reg + a_zsq_reg;
            b_side_reg.x <= a_x_reg;
            b_side_reg.y <= a_y_reg;
        end
    end

    // ---------------------------------------------------------------
    // Magnitudes with 8 fraction bits
    // ---------------------------------------------------------------
    logic              sq_vld;
    logic [MW-1:0]     mxz, myz;
    atl_pkg::sq_side_t sq_side;

    atl_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .vld_in   (b_vld_reg),
        .sum_xz   (b_sxz_reg),
        .sum_yz   (b_syz_reg),
        .side_in  (b_side_reg),
        .vld_out  (sq_vld),
        .mag_xz   (mxz),
        .mag_yz   (myz),
        .side_out (sq_side)
    );

    // ---------------------------------------------------------------
    // Stage C: operand prep. Each lane gets |num| and |den|, the result
    // sign, and the fixed answer for a zero denominator.
    //   lane 0: y*256 over mag(x,z)
    //   lane 1: -x*256 over mag(y,z)
    //   lane 2: mag(x,z) over y*256
    // ---------------------------------------------------------------
    logic [SW-1:0] abs_x, abs_y;
    logic [MW-1:0] ax256, ay256;
    logic          x_neg, y_neg, x_zero, y_zero;

    // Negating the most negative sample in SW bits gives its exact magnitude.
    assign x_neg  = sq_side.x[SW-1];
    assign y_neg  = sq_side.y[SW-1];
    assign x_zero = (sq_side.x == '0);
    assign y_zero = (sq_side.y == '0);
    assign abs_x  = x_neg ? SW'(-sq_side.x) : sq_side.x;
    assign abs_y  = y_neg ? SW'(-sq_side.y) : sq_side.y;
    assign ax256  = {abs_x, {FR{1'b0}}};
    assign ay256  = {abs_y, {FR{1'b0}}};

    logic [MW-1:0]  c_a_next   [L];
    logic [MW-1:0]  c_b_next   [L];
    atl_pkg::flag_t c_flg_next [L];

    always_comb begin
        c_a_next[0]            = ay256;
        c_b_next[0]            = mxz;
        c_flg_next[0].neg      = y_neg;
        c_flg_next[0].spec     = (mxz == '0);
        c_flg_next[0].spec_deg = y_zero ? atl_pkg::DEG_NONE
                               : (y_neg ? -atl_pkg::DEG_RIGHT : atl_pkg::DEG_RIGHT);

        c_a_next[1]            = ax256;
        c_b_next[1]            = myz;
        c_flg_next[1].neg      = !x_neg && !x_zero;
        c_flg_next[1].spec     = (myz == '0);
        c_flg_next[1].spec_deg = x_zero ? atl_pkg::DEG_NONE
                               : (x_neg ? atl_pkg::DEG_RIGHT : -atl_pkg::DEG_RIGHT);

        c_a_next[2]            = mxz;
        c_b_next[2]            = ay256;
        c_flg_next[2].neg      = y_neg;
        c_flg_next[2].spec     = y_zero;
        c_flg_next[2].spec_deg = (mxz == '0) ? atl_pkg::DEG_NONE : atl_pkg::DEG_RIGHT;
    end

    logic           c_vld_reg;
    logic [MW-1:0]  c_a_reg   [L];
    logic [MW-1:0]  c_b_reg   [L];
    atl_pkg::flag_t c_flg_reg [L];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_vld_reg <= 1'b0;
        end else if (en) begin
            c_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_a_reg   <= c_a_next;
            c_b_reg   <= c_b_next;
            c_flg_reg <= c_flg_next;
        end
    end

    // ---------------------------------------------------------------
    // Arctangent in radians, then degrees; the last degree stage is the
    // output register.
    // ---------------------------------------------------------------
    logic                             cor_vld;
    logic signed [atl_pkg::ZW-1:0]    cor_z   [L];
    atl_pkg::flag_t                   cor_flg [L];
    logic signed [atl_pkg::DEG_W-1:0] deg     [L];

    atl_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (c_vld_reg),
        .a_in    (c_a_reg),
        .b_in    (c_b_reg),
        .flg_in  (c_flg_reg),
        .vld_out (cor_vld),
        .z_out   (cor_z),
        .flg_out (cor_flg)
    );

    atl_deg u_deg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (cor_vld),
        .z_in    (cor_z),
        .flg_in  (cor_flg),
        .vld_out (m_valid),
        .deg_out (deg)
    );

    assign m_data.angle_about_x = deg[0];
    assign m_data.angle_about_y = deg[1];
    assign m_data.angle_about_z = deg[2];

`ifndef SYNTHESIS
    // Drop every item in flight on reset.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Every angle stays within a quarter turn.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.angle_about_x <= atl_pkg::DEG_RIGHT
                 && m_data.angle_about_x >= -atl_pkg::DEG_RIGHT
                 && m_data.angle_about_y <= atl_pkg::DEG_RIGHT
                 && m_data.angle_about_y >= -atl_pkg::DEG_RIGHT
                 && m_data.angle_about_z <= atl_pkg::DEG_RIGHT
                 && m_data.angle_about_z >= -atl_pkg::DEG_RIGHT)
        else $error("angle out of range");

    // Both y-driven angles take their sign from y, so they never disagree.
    a_xz_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.angle_about_x > atl_pkg::DEG_NONE
                      && m_data.angle_about_z < atl_pkg::DEG_NONE)
                 && !(m_data.angle_about_x < atl_pkg::DEG_NONE
                      && m_data.angle_about_z > atl_pkg::DEG_NONE))
        else $error("x and z angles disagree in sign");
`endif

endmodule
